// ===== hdl/buzzer_linear_frequency_sweep_core_assert.svh =====
// ----------------------------------------------------------------------------
// buzzer sweep assertion macros
// shared check forms for the sweep core; expect clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef BUZZER_LINEAR_FREQUENCY_SWEEP_CORE_ASSERT_SVH
`define BUZZER_LINEAR_FREQUENCY_SWEEP_CORE_ASSERT_SVH

// same-cycle implication
`define BLFS_ASSERT_IMPLY(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("blfs: same-cycle check failed");

// next-cycle implication
`define BLFS_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("blfs: next-cycle check failed");

`endif

// ===== hdl/blfs_pkg.sv =====
// ----------------------------------------------------------------------------
// blfs_pkg
// types and fixed constants of the buzzer frequency sweep core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blfs_pkg;

    // field widths
    localparam int FREQ_W        = 16;
    localparam int DIVIDER_W     = 8;
    localparam int FRAC_BITS     = 12;
    localparam int RATIO_W       = FREQ_W + FRAC_BITS;
    localparam int TONE_PRESCALE = 64;
    localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 8'd50;

    // action codes
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } blfs_action_t;

    // input item
    typedef struct packed {
        logic [1:0]        action;
        logic [FREQ_W-1:0] start_freq;
        logic [FREQ_W-1:0] end_freq;
        logic [FREQ_W-1:0] sweep_ticks;
    } blfs_in_t;

    // result item
    typedef struct packed {
        logic                 tone_enable;
        logic [DIVIDER_W-1:0] divider;
        logic                 divider_written;
    } blfs_out_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_go;
        logic div_tone;
        logic mul_go;
        logic commit;
    } blfs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       long_sweep;
        logic       div_done;
    } blfs_stat_t;

endpackage

// ===== hdl/blfs_if.sv =====
// ----------------------------------------------------------------------------
// blfs channel interfaces
// valid/ready channels carrying sweep commands and tone results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface blfs_in_if;
    import blfs_pkg::*;

    logic     valid;
    logic     ready;
    blfs_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface blfs_out_if;
    import blfs_pkg::*;

    logic      valid;
    logic      ready;
    blfs_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/blfs_datapath.sv =====
// ----------------------------------------------------------------------------
// blfs_datapath
// sweep state, shared serial divider, delta scaling multiplier, result regs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blfs_datapath #(
    parameter int CPU_CLOCK_HZ = 16000000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  blfs_pkg::blfs_cmd_t cmd,
    input  blfs_pkg::blfs_in_t  item,
    output blfs_pkg::blfs_stat_t stat,
    output blfs_pkg::blfs_out_t result
);
    import blfs_pkg::*;

    localparam int TONE_BASE = CPU_CLOCK_HZ / TONE_PRESCALE;
    localparam int TB_W      = $clog2(TONE_BASE + 1);
    localparam int DIV_W     = (TB_W > RATIO_W) ? TB_W : RATIO_W;
    localparam int CNT_W     = $clog2(DIV_W + 1);

    // captured item
    blfs_in_t item_reg;

    // sweep state
    logic [FREQ_W-1:0]    target_reg;
    logic [FREQ_W-1:0]    total_reg;
    logic [FREQ_W-1:0]    delta_reg;
    logic [FREQ_W-1:0]    ticks_left_reg;
    logic                 tone_on_reg;
    logic [DIVIDER_W-1:0] compare_reg;
    logic                 written_reg;

    // divider
    logic [FREQ_W-1:0] divisor_reg;
    logic [FREQ_W-1:0] rem_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              div_busy_reg;
    logic              div_done_reg;

    // scaled offset
    logic [FREQ_W-1:0] offset_reg;

    logic [FREQ_W:0]        rem_shift;
    logic                   rem_ge;
    logic [FREQ_W:0]        rem_diff;
    logic [RATIO_W-1:0]     delta_ext;
    logic [RATIO_W-1:0]     mul_low;
    logic [FREQ_W-1:0]      sweep_freq;
    logic [DIVIDER_W-1:0]   div_byte;

    // one restoring step
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    // delta times ratio, low bits only
    assign delta_ext = {{(RATIO_W - FREQ_W){delta_reg[FREQ_W-1]}}, delta_reg};
    assign mul_low   = quo_reg[RATIO_W-1:0] * delta_ext;

    // frequency for this tick and divider byte from quotient
    assign sweep_freq = target_reg + offset_reg;
    assign div_byte   = quo_reg[DIVIDER_W-1:0] - DIVIDER_W'(1);

    // status back to the controller
    assign stat.action     = item_reg.action;
    assign stat.long_sweep = (ticks_left_reg > FREQ_W'(1));
    assign stat.div_done   = div_done_reg;

    // result fields come straight from state
    assign result.tone_enable     = tone_on_reg;
    assign result.divider         = compare_reg;
    assign result.divider_written = written_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
    end

    // serial divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            if (cmd.div_go)
            begin
                div_busy_reg <= 1'b1;
                cnt_reg      <= CNT_W'(DIV_W);
            end
            else if (div_busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    // divider operands and partial results
    always_ff @(posedge clk)
    begin
        if (cmd.div_go)
        begin
            rem_reg <= '0;
            if (!cmd.div_tone)
            begin
                quo_reg     <= DIV_W'({ticks_left_reg, {FRAC_BITS{1'b0}}});
                divisor_reg <= total_reg;
            end
            else
            begin
                quo_reg <= DIV_W'(TONE_BASE);
                if (item_reg.action == ACT_START)
                begin
                    divisor_reg <= item_reg.start_freq;
                end
                else
                begin
                    divisor_reg <= sweep_freq;
                end
            end
        end
        else if (div_busy_reg)
        begin
            rem_reg <= rem_ge ? rem_diff[FREQ_W-1:0] : rem_shift[FREQ_W-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], rem_ge};
        end
    end

    // scaled offset register
    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            offset_reg <= mul_low[RATIO_W-1:FRAC_BITS];
        end
    end

    // state update when the item is finished
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= '0;
            total_reg      <= '0;
            delta_reg      <= '0;
            ticks_left_reg <= '0;
            tone_on_reg    <= 1'b0;
            compare_reg    <= DIVIDER_RESET;
            written_reg    <= 1'b0;
        end
        else if (cmd.commit)
        begin
            written_reg <= 1'b0;
            case (item_reg.action)
                ACT_START:
                begin
                    target_reg     <= item_reg.end_freq;
                    total_reg      <= item_reg.sweep_ticks;
                    delta_reg      <= item_reg.start_freq - item_reg.end_freq;
                    ticks_left_reg <= item_reg.sweep_ticks;
                    compare_reg    <= div_byte;
                    tone_on_reg    <= 1'b1;
                    written_reg    <= 1'b1;
                end
                ACT_STOP:
                begin
                    ticks_left_reg <= '0;
                    tone_on_reg    <= 1'b0;
                end
                ACT_TICK:
                begin
                    if (ticks_left_reg == FREQ_W'(1))
                    begin
                        tone_on_reg <= 1'b0;
                    end
                    if (ticks_left_reg > FREQ_W'(1))
                    begin
                        compare_reg <= div_byte;
                        written_reg <= 1'b1;
                    end
                    if (ticks_left_reg != '0)
                    begin
                        ticks_left_reg <= ticks_left_reg - FREQ_W'(1);
                    end
                end
                default:
                begin
                    written_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== hdl/blfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// blfs_ctrl
// sequencer for the sweep core: handshakes, divider and multiplier steps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "buzzer_linear_frequency_sweep_core_assert.svh"

module blfs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  blfs_pkg::blfs_stat_t stat,
    output blfs_pkg::blfs_cmd_t  cmd
);
    import blfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RATIO,
        S_SCALE,
        S_TONE,
        S_COMMIT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   div_go_reg;
    logic   div_tone_reg;
    logic   mul_go_reg;
    logic   commit;

    // finish the item once the result slot is free
    assign commit = (state_reg == S_COMMIT) && (!out_valid_reg || out_ready);

    assign in_ready     = in_ready_reg;
    assign out_valid    = out_valid_reg;
    assign cmd.capture  = in_valid && in_ready_reg;
    assign cmd.div_go   = div_go_reg;
    assign cmd.div_tone = div_tone_reg;
    assign cmd.mul_go   = mul_go_reg;
    assign cmd.commit   = commit;

    // state and registered commands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
            div_go_reg    <= 1'b0;
            div_tone_reg  <= 1'b0;
            mul_go_reg    <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;

            // result slot
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        in_ready_reg <= 1'b0;
                        state_reg    <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (stat.action == ACT_START)
                    begin
                        div_go_reg   <= 1'b1;
                        div_tone_reg <= 1'b1;
                        state_reg    <= S_TONE;
                    end
                    else if (stat.action == ACT_TICK && stat.long_sweep)
                    begin
                        div_go_reg   <= 1'b1;
                        div_tone_reg <= 1'b0;
                        state_reg    <= S_RATIO;
                    end
                    else
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_RATIO:
                begin
                    if (stat.div_done)
                    begin
                        mul_go_reg <= 1'b1;
                        state_reg  <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    div_go_reg   <= 1'b1;
                    div_tone_reg <= 1'b1;
                    state_reg    <= S_TONE;
                end
                S_TONE:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_COMMIT;
                    end
                end
                S_COMMIT:
                begin
                    if (commit)
                    begin
                        in_ready_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // checks
    `BLFS_ASSERT_NEXT(a_commit_shows_result, commit, out_valid_reg)
    `BLFS_ASSERT_NEXT(a_accept_closes_input, in_valid && in_ready_reg, !in_ready_reg)
    `BLFS_ASSERT_IMPLY(a_done_when_waiting, stat.div_done,
                       state_reg == S_RATIO || state_reg == S_TONE)
    `BLFS_ASSERT_IMPLY(a_commit_input_closed, commit, !in_ready_reg)

endmodule

// ===== hdl/buzzer_linear_frequency_sweep_core.sv =====
// ----------------------------------------------------------------------------
// buzzer_linear_frequency_sweep_core
// linear frequency sweep controller producing buzzer timer divider values
//
//   channel   dir   payload                                        item
//   in_ch     in    action, start_freq, end_freq, sweep_ticks       command
//   out_ch    out   tone_enable, divider, divider_written           result
//
// stop, short ticks and unused codes skip the divider; a start runs it once for
// the tone, a sweep tick twice (ratio, then tone) with a multiply between; the
// shared divider makes one quotient bit per cycle (DIV_W = 28 at default clock)
// reset is asynchronous, active low; sweep state returns to idle, divider 50
// the next item is taken while a result waits; it finishes once out_ch frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buzzer_linear_frequency_sweep_core #(
    parameter int CPU_CLOCK_HZ = 16000000
) (
    input  logic              clk,
    input  logic              rst_n,
    blfs_in_if.sink           in_ch,
    blfs_out_if.source        out_ch
);
    import blfs_pkg::*;

    blfs_cmd_t  cmd;
    blfs_stat_t stat;
    blfs_out_t  result;

    // sequencer
    blfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and sweep state
    blfs_datapath #(
        .CPU_CLOCK_HZ (CPU_CLOCK_HZ)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (in_ch.payload),
        .stat   (stat),
        .result (result)
    );

    assign out_ch.payload = result;

endmodule
